[src/tsim_pkg.sv]
// Shared constants and types of the transport stream integrity monitor.
package tsim_pkg;

  localparam int unsigned PID_W      = 13;
  localparam int unsigned CC_DEPTH   = 8192;
  localparam int unsigned CC_ENTRY_W = 5;
  localparam int unsigned BYTE_W     = 8;
  localparam int unsigned CC_W       = 4;
  localparam int unsigned FIELD_W    = 48;
  localparam int unsigned WALL_W     = 48;
  localparam int unsigned PCR_W      = 42;
  localparam int unsigned BASE_LSB   = 15;
  localparam int unsigned EXT_W      = 9;
  localparam int unsigned DIFF_W     = PCR_W + 1;
  localparam int unsigned W5_W       = WALL_W + 3;
  localparam int unsigned P5_W       = PCR_W + 3;

  localparam int unsigned PADDR_W    = 3;
  localparam int unsigned PDATA_W    = 32;
  localparam logic [0:0]  REG_PCR_PID = 1'b0;

  // Header bit positions.
  localparam int unsigned CTL_ADAPT_BIT   = 5;
  localparam int unsigned CTL_PAYLOAD_BIT = 4;
  localparam int unsigned FLG_DISC_BIT    = 7;
  localparam int unsigned FLG_PCR_BIT     = 4;

  localparam logic [BYTE_W-1:0] SYNC_VALUE   = 8'h47;
  localparam logic [BYTE_W-1:0] ALEN_PCR_MIN = 8'd7;

  // PCR wraps at 2^33 * 300 ticks.
  localparam logic [PCR_W-1:0] PCR_WRAP = 42'd2576980377600;
  // A difference that drops below zero in 64-bit unsigned arithmetic folds
  // through 2^64; this is 2^64 modulo the wrap, added back in that case.
  localparam logic [PCR_W-1:0] WRAP_FOLD = 42'd2130303778816;
  localparam logic [PCR_W-1:0] PCR_MULT  = 42'd300;
  // Sixty seconds and half a second at 27 MHz.
  localparam logic [PCR_W-1:0] JUMP_MAX       = 42'd1620000000;
  localparam int unsigned      HALF_SEC_TICKS = 13500000;

  typedef struct packed {
    logic             sync_ok;
    logic [PID_W-1:0] pid;
    logic [CC_W-1:0]  cc;
    logic             payload;
    logic             disc;
  } cc_req_t;

  typedef struct packed {
    logic s1_fire;
    logic ld2;
    logic ld3;
    logic ld4;
  } pipe_ctl_t;

endpackage

[src/tsim_hdr_if.sv]
// Input channel carrying one packet header and its arrival time.
interface tsim_hdr_if;
  logic                             valid;
  logic                             ready;
  logic [tsim_pkg::BYTE_W-1:0]      sync_byte;
  logic [tsim_pkg::PID_W-1:0]       packet_pid;
  logic [tsim_pkg::BYTE_W-1:0]      control_byte;
  logic [tsim_pkg::BYTE_W-1:0]      adapt_length;
  logic [tsim_pkg::BYTE_W-1:0]      adapt_flags;
  logic [tsim_pkg::FIELD_W-1:0]     pcr_field;
  logic [tsim_pkg::WALL_W-1:0]      wall_ticks;

  modport source (output valid, sync_byte, packet_pid, control_byte, adapt_length,
                  adapt_flags, pcr_field, wall_ticks, input ready);
  modport sink (input valid, sync_byte, packet_pid, control_byte, adapt_length,
                adapt_flags, pcr_field, wall_ticks, output ready);
endinterface

[src/tsim_res_if.sv]
// Output channel carrying the check results of one packet.
interface tsim_res_if;
  logic                        valid;
  logic                        ready;
  logic                        sync_error;
  logic                        discontinuity_seen;
  logic                        continuity_error;
  logic                        pcr_found;
  logic                        pcr_error;
  logic [tsim_pkg::PCR_W-1:0]  pcr_value;

  modport source (output valid, sync_error, discontinuity_seen, continuity_error,
                  pcr_found, pcr_error, pcr_value, input ready);
  modport sink (input valid, sync_error, discontinuity_seen, continuity_error,
                pcr_found, pcr_error, pcr_value, output ready);
endinterface

[src/tsim_ram.sv]
// Generic single-write, single-read RAM with registered read data.
module tsim_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 256,
  localparam int unsigned AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[src/tsim_cc_unit.sv]
// Per-PID continuity counter store with clearing sweep and write forwarding.
module tsim_cc_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        rd_en_i,
  input  logic [tsim_pkg::PID_W-1:0]  rd_pid_i,
  input  tsim_pkg::cc_req_t           req_i,
  input  logic                        fire_i,
  output logic                        clearing_o,
  output logic                        cont_err_o
);

  logic                              clr_busy_q;
  logic [tsim_pkg::PID_W-1:0]        clr_addr_q;
  logic                              item_we;
  logic                              ram_we;
  logic [tsim_pkg::PID_W-1:0]        ram_waddr;
  logic [tsim_pkg::CC_ENTRY_W-1:0]   ram_wdata;
  logic [tsim_pkg::CC_ENTRY_W-1:0]   ram_rdata;
  logic [tsim_pkg::CC_ENTRY_W-1:0]   entry;
  logic                              fwd_v_q;
  logic [tsim_pkg::PID_W-1:0]        fwd_addr_q;
  logic [tsim_pkg::CC_ENTRY_W-1:0]   fwd_data_q;

  // After reset every entry is swept to zero, one per cycle.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_busy_q) begin
      clr_addr_q <= clr_addr_q + tsim_pkg::PID_W'(1);
      if (clr_addr_q == tsim_pkg::PID_W'(tsim_pkg::CC_DEPTH - 1)) begin
        clr_busy_q <= 1'b0;
      end
    end
  end

  assign item_we   = fire_i && req_i.sync_ok && req_i.payload;
  assign ram_we    = clr_busy_q || item_we;
  assign ram_waddr = clr_busy_q ? clr_addr_q : req_i.pid;
  assign ram_wdata = clr_busy_q ? '0 : {1'b1, req_i.cc};

  tsim_ram #(
    .Width (tsim_pkg::CC_ENTRY_W),
    .Depth (tsim_pkg::CC_DEPTH)
  ) u_store (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en_i),
    .raddr_i (rd_pid_i),
    .rdata_o (ram_rdata)
  );

  // The last item write is kept; a read at the same edge sees old data, so
  // a matching PID takes the kept value instead. Older writes agree with it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_v_q <= 1'b0;
    end else if (item_we) begin
      fwd_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (item_we) begin
      fwd_addr_q <= req_i.pid;
      fwd_data_q <= ram_wdata;
    end
  end

  assign entry = (fwd_v_q && fwd_addr_q == req_i.pid) ? fwd_data_q : ram_rdata;

  assign cont_err_o = req_i.sync_ok && req_i.payload && entry[tsim_pkg::CC_W] &&
                      !req_i.disc &&
                      (req_i.cc != entry[tsim_pkg::CC_W-1:0] + tsim_pkg::CC_W'(1));
  assign clearing_o = clr_busy_q;

endmodule

[src/tsim_pcr_unit.sv]
// PCR extraction and plausibility pipeline against the arrival wall clock.
module tsim_pcr_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  tsim_pkg::pipe_ctl_t           ctl_i,
  input  logic                          found_i,
  input  logic [tsim_pkg::FIELD_W-1:0]  field_i,
  input  logic [tsim_pkg::WALL_W-1:0]   wall_i,
  output logic                          found_o,
  output logic                          err_o,
  output logic [tsim_pkg::PCR_W-1:0]    value_o
);

  localparam logic signed [tsim_pkg::DIFF_W-1:0] WrapS =
    $signed(tsim_pkg::DIFF_W'(tsim_pkg::PCR_WRAP));
  localparam logic signed [tsim_pkg::DIFF_W-1:0] FoldS =
    $signed(tsim_pkg::DIFF_W'(tsim_pkg::WRAP_FOLD));

  logic [tsim_pkg::PCR_W-1:0]          value1;
  logic                                have_q;
  logic [tsim_pkg::PCR_W-1:0]          prev_pcr_q;
  logic [tsim_pkg::WALL_W-1:0]         prev_wall_q;

  logic                                found2_q, have2_q;
  logic [tsim_pkg::PCR_W-1:0]          value2_q, last2_q;
  logic [tsim_pkg::WALL_W-1:0]         wall2_q, then2_q;

  logic                                found3_q, have3_q, gt3_q;
  logic [tsim_pkg::PCR_W-1:0]          value3_q;
  logic signed [tsim_pkg::DIFF_W-1:0]  d3_q;
  logic [tsim_pkg::WALL_W-1:0]         wdiff3_q;

  logic                                found4_q, have4_q, gt4_q;
  logic [tsim_pkg::PCR_W-1:0]          value4_q, p4_q;
  logic [tsim_pkg::W5_W-1:0]           w5c4_q;
  logic [tsim_pkg::WALL_W-1:0]         wdiff4_q;

  logic [tsim_pkg::PCR_W-1:0]          p_d;
  logic [tsim_pkg::W5_W-1:0]           w5c_d;
  logic [tsim_pkg::P5_W-1:0]           p5c;
  logic                                jump_ok;

  // Base sits in bits 47..15, extension in bits 8..0.
  assign value1 = tsim_pkg::PCR_W'(field_i[tsim_pkg::FIELD_W-1:tsim_pkg::BASE_LSB]) *
                  tsim_pkg::PCR_MULT +
                  tsim_pkg::PCR_W'(field_i[tsim_pkg::EXT_W-1:0]);

  // The previous PCR moves on as soon as an item with a PCR leaves the first stage,
  // so the next item already compares against it.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q      <= 1'b0;
      prev_pcr_q  <= '0;
      prev_wall_q <= '0;
    end else if (ctl_i.s1_fire && found_i) begin
      have_q      <= 1'b1;
      prev_pcr_q  <= value1;
      prev_wall_q <= wall_i;
    end
  end

  always_comb begin
    if (d3_q >= WrapS) begin
      p_d = tsim_pkg::PCR_W'(d3_q - WrapS);
    end else if (!d3_q[tsim_pkg::DIFF_W-1]) begin
      p_d = tsim_pkg::PCR_W'(d3_q);
    end else if (d3_q >= -WrapS) begin
      p_d = tsim_pkg::PCR_W'(d3_q + WrapS);
    end else begin
      p_d = tsim_pkg::PCR_W'(d3_q + WrapS + FoldS);
    end
  end

  assign w5c_d = (tsim_pkg::W5_W'(wdiff3_q) << 2) + tsim_pkg::W5_W'(wdiff3_q) +
                 tsim_pkg::W5_W'(tsim_pkg::HALF_SEC_TICKS);

  always_ff @(posedge clk_i) begin
    if (ctl_i.ld2) begin
      found2_q <= found_i;
      have2_q  <= have_q;
      value2_q <= value1;
      last2_q  <= prev_pcr_q;
      wall2_q  <= wall_i;
      then2_q  <= prev_wall_q;
    end
    if (ctl_i.ld3) begin
      found3_q <= found2_q;
      have3_q  <= have2_q;
      value3_q <= value2_q;
      d3_q     <= $signed({1'b0, value2_q}) - $signed({1'b0, last2_q});
      wdiff3_q <= wall2_q - then2_q;
      gt3_q    <= wall2_q > then2_q;
    end
    if (ctl_i.ld4) begin
      found4_q <= found3_q;
      have4_q  <= have3_q;
      value4_q <= value3_q;
      p4_q     <= p_d;
      w5c4_q   <= w5c_d;
      wdiff4_q <= wdiff3_q;
      gt4_q    <= gt3_q;
    end
  end

  assign p5c = (tsim_pkg::P5_W'(p4_q) << 2) + tsim_pkg::P5_W'(p4_q) +
               tsim_pkg::P5_W'(tsim_pkg::HALF_SEC_TICKS);

  assign jump_ok = gt4_q && (p4_q != '0) && (p4_q < tsim_pkg::JUMP_MAX) &&
                   (tsim_pkg::W5_W'(p4_q) < w5c4_q) &&
                   (tsim_pkg::WALL_W'(p5c) > wdiff4_q);

  assign found_o = found4_q;
  assign err_o   = found4_q && have4_q && !jump_ok;
  assign value_o = found4_q ? value4_q : '0;

endmodule

[src/ts_integrity_monitor.sv]
// Top level of the transport stream header integrity monitor.
//
//   Port group     Direction  Handshake      Contents
//   hdr_i          in         valid/ready    one packet header and arrival time
//   res_o          out        valid/ready    sync, discontinuity, continuity, PCR flags
//   APB (p*)       in/out     psel/penable   pcr_source_pid at byte address 0
//
// One item enters per cycle when the output side keeps up; its result moves on
// from the first stage through stages two to four into the output register.
// The continuity store is one 8192-entry RAM, read at acceptance and written as
// the item leaves the first stage; a kept copy of the last write covers a read
// at that same edge. After reset the store is swept to zero, and during the sweep
// hdr_i.ready is low. Stages advance only into room, so bubbles close up.
module ts_integrity_monitor (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  tsim_hdr_if.sink                      hdr_i,
  tsim_res_if.source                    res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tsim_pkg::PADDR_W-1:0]  paddr,
  input  logic [tsim_pkg::PDATA_W-1:0]  pwdata,
  output logic [tsim_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  // Configuration register.
  logic [tsim_pkg::PID_W-1:0] pcr_pid_q;
  logic [0:0]                 reg_idx;

  assign reg_idx = paddr[tsim_pkg::PADDR_W-1:2];
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pcr_pid_q <= '0;
    end else if (psel && penable && pwrite && reg_idx == tsim_pkg::REG_PCR_PID) begin
      pcr_pid_q <= pwdata[tsim_pkg::PID_W-1:0];
    end
  end

  assign prdata = (reg_idx == tsim_pkg::REG_PCR_PID) ?
                  tsim_pkg::PDATA_W'(pcr_pid_q) : '0;

  // Pipeline occupancy and room. A stage loads whenever it has room.
  logic v1_q, v2_q, v3_q, v4_q, out_v_q;
  logic room1, room2, room3, room4, room_out;
  logic in_accept;
  logic clearing;

  assign room_out  = !out_v_q || res_o.ready;
  assign room4     = !v4_q || room_out;
  assign room3     = !v3_q || room4;
  assign room2     = !v2_q || room3;
  assign room1     = !v1_q || room2;
  assign hdr_i.ready = room1 && !clearing;
  assign in_accept = hdr_i.valid && hdr_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q    <= 1'b0;
      v2_q    <= 1'b0;
      v3_q    <= 1'b0;
      v4_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      if (room1)    v1_q    <= in_accept;
      if (room2)    v2_q    <= v1_q;
      if (room3)    v3_q    <= v2_q;
      if (room4)    v4_q    <= v3_q;
      if (room_out) out_v_q <= v4_q;
    end
  end

  // First stage: the accepted header, while the store read completes.
  logic [tsim_pkg::BYTE_W-1:0]   sync1_q, ctl1_q, alen1_q, flags1_q;
  logic [tsim_pkg::PID_W-1:0]    pid1_q;
  logic [tsim_pkg::FIELD_W-1:0]  field1_q;
  logic [tsim_pkg::WALL_W-1:0]   wall1_q;

  always_ff @(posedge clk_i) begin
    if (room1) begin
      sync1_q  <= hdr_i.sync_byte;
      pid1_q   <= hdr_i.packet_pid;
      ctl1_q   <= hdr_i.control_byte;
      alen1_q  <= hdr_i.adapt_length;
      flags1_q <= hdr_i.adapt_flags;
      field1_q <= hdr_i.pcr_field;
      wall1_q  <= hdr_i.wall_ticks;
    end
  end

  logic sync_ok1, adapt1, disc1, found1, cont_err1;
  tsim_pkg::cc_req_t   cc_req;
  tsim_pkg::pipe_ctl_t pipe_ctl;

  assign sync_ok1 = (sync1_q == tsim_pkg::SYNC_VALUE);
  assign adapt1   = ctl1_q[tsim_pkg::CTL_ADAPT_BIT];
  // Discontinuity needs at least one adaptation byte.
  assign disc1    = sync_ok1 && adapt1 && (alen1_q != '0) &&
                    flags1_q[tsim_pkg::FLG_DISC_BIT];
  // A PCR needs seven adaptation bytes, the PCR flag and the configured PID;
  // a zero PID turns the check off.
  assign found1   = sync_ok1 && (pcr_pid_q != '0) && (pid1_q == pcr_pid_q) &&
                    adapt1 && (alen1_q >= tsim_pkg::ALEN_PCR_MIN) &&
                    flags1_q[tsim_pkg::FLG_PCR_BIT];

  assign cc_req.sync_ok = sync_ok1;
  assign cc_req.pid     = pid1_q;
  assign cc_req.cc      = ctl1_q[tsim_pkg::CC_W-1:0];
  assign cc_req.payload = ctl1_q[tsim_pkg::CTL_PAYLOAD_BIT];
  assign cc_req.disc    = disc1;

  assign pipe_ctl.s1_fire = v1_q && room2;
  assign pipe_ctl.ld2     = room2;
  assign pipe_ctl.ld3     = room3;
  assign pipe_ctl.ld4     = room4;

  tsim_cc_unit u_cc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_en_i    (in_accept),
    .rd_pid_i   (hdr_i.packet_pid),
    .req_i      (cc_req),
    .fire_i     (pipe_ctl.s1_fire),
    .clearing_o (clearing),
    .cont_err_o (cont_err1)
  );

  logic                       pcr_found4, pcr_err4;
  logic [tsim_pkg::PCR_W-1:0] pcr_value4;

  tsim_pcr_unit u_pcr (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctl_i   (pipe_ctl),
    .found_i (found1),
    .field_i (field1_q),
    .wall_i  (wall1_q),
    .found_o (pcr_found4),
    .err_o   (pcr_err4),
    .value_o (pcr_value4)
  );

  // Header flags travel alongside the PCR arithmetic.
  logic sync_err2_q, disc2_q, cont2_q;
  logic sync_err3_q, disc3_q, cont3_q;
  logic sync_err4_q, disc4_q, cont4_q;
  logic                       out_sync_err_q, out_disc_q, out_cont_q;
  logic                       out_found_q, out_perr_q;
  logic [tsim_pkg::PCR_W-1:0] out_value_q;

  always_ff @(posedge clk_i) begin
    if (room2) begin
      sync_err2_q <= !sync_ok1;
      disc2_q     <= disc1;
      cont2_q     <= cont_err1;
    end
    if (room3) begin
      sync_err3_q <= sync_err2_q;
      disc3_q     <= disc2_q;
      cont3_q     <= cont2_q;
    end
    if (room4) begin
      sync_err4_q <= sync_err3_q;
      disc4_q     <= disc3_q;
      cont4_q     <= cont3_q;
    end
    if (room_out) begin
      out_sync_err_q <= sync_err4_q;
      out_disc_q     <= disc4_q;
      out_cont_q     <= cont4_q;
      out_found_q    <= pcr_found4;
      out_perr_q     <= pcr_err4;
      out_value_q    <= pcr_value4;
    end
  end

  assign res_o.valid              = out_v_q;
  assign res_o.sync_error         = out_sync_err_q;
  assign res_o.discontinuity_seen = out_disc_q;
  assign res_o.continuity_error   = out_cont_q;
  assign res_o.pcr_found          = out_found_q;
  assign res_o.pcr_error          = out_perr_q;
  assign res_o.pcr_value          = out_value_q;

  // No item may enter while the store is still being cleared.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    clearing |-> !in_accept)
    else $error("item accepted during store clearing");

  // A sync error stands alone in its result.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_sync_err_q |->
      !(out_disc_q || out_cont_q || out_found_q || out_perr_q))
    else $error("sync error result carries other flags");

  // A PCR error is only reported on an extracted PCR.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_perr_q |-> out_found_q)
    else $error("PCR error without PCR");

  // A flagged discontinuity suppresses the continuity check.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_cont_q |-> !out_disc_q)
    else $error("continuity error on a discontinuity");

endmodule
